### rtl/edb_pkg.sv
`default_nettype none

package edb_pkg;

    // Line store depth default and fixed field widths
    localparam int unsigned MAX_WIDTH_DEF = 1024;
    localparam int unsigned PIX_W         = 8;
    localparam int unsigned ERR_W         = 9;
    localparam int unsigned CFG_WIDTH_W   = 11;
    localparam int unsigned CFG_HEIGHT_W  = 13;
    localparam int unsigned ROW_W         = 12;
    localparam int unsigned MAX_HEIGHT    = 4096;
    localparam int unsigned APB_ADDR_W    = 3;
    localparam int unsigned APB_DATA_W    = 32;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd512;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd512;

    localparam logic [PIX_W-1:0] THRESHOLD   = 8'd128;
    localparam logic [PIX_W-1:0] PIX_MAX     = 8'd255;
    localparam logic [ERR_W-1:0] WHITE_LEVEL = 9'd255;

    // Diffusion weights, in sixteenths
    localparam logic [2:0] WT_ABOVE_LEFT  = 3'd1;
    localparam logic [2:0] WT_ABOVE       = 3'd5;
    localparam logic [2:0] WT_ABOVE_RIGHT = 3'd3;
    localparam logic [2:0] WT_LEFT        = 3'd7;

    // Register word index (paddr[2])
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    typedef logic signed [ERR_W-1:0] t_err;

    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_col;
    } t_pos;

    typedef struct packed {
        logic is_white;
        logic row_end;
        logic frame_end;
    } t_result;

    // pix + trunc0(err * wt / 16), saturated to 0..255
    function automatic logic [PIX_W-1:0] sat_add(
        input logic [PIX_W-1:0] pix,
        input t_err             err,
        input logic [2:0]       wt
    );
        logic signed [12:0] prod;
        logic signed [12:0] share;
        logic signed [10:0] sum;
        prod  = 13'(err) * $signed({10'd0, wt});
        share = prod[12] ? ((prod + 13'sd15) >>> 4) : (prod >>> 4);
        sum   = 11'(share) + $signed({3'd0, pix});
        if (sum > 11'sd255) begin
            return PIX_MAX;
        end else if (sum < 11'sd0) begin
            return '0;
        end else begin
            return sum[PIX_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### rtl/edb_line_mem.sv
`default_nettype none

module edb_line_mem #(
    parameter int unsigned AW = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire edb_pkg::t_err i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output edb_pkg::t_err      o_rd_data
);

    localparam int unsigned DEPTH = 1 << AW;

    edb_pkg::t_err r_mem [DEPTH];
    edb_pkg::t_err r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Forward a same-cycle write so the read sees the new word
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/edb_diffuse.sv
`default_nettype none

module edb_diffuse (
    input  wire logic [edb_pkg::PIX_W-1:0] i_pixel_value,
    input  wire edb_pkg::t_err             i_above_left,
    input  wire edb_pkg::t_err             i_above,
    input  wire edb_pkg::t_err             i_above_right,
    input  wire edb_pkg::t_err             i_left,
    input  wire edb_pkg::t_pos             i_pos,
    output logic                           o_is_white,
    output edb_pkg::t_err                  o_err
);

    logic [edb_pkg::PIX_W-1:0] v_al;
    logic [edb_pkg::PIX_W-1:0] v_a;
    logic [edb_pkg::PIX_W-1:0] v_ar;
    logic [edb_pkg::PIX_W-1:0] v_l;

    // Apply shares in fixed order; drop those from outside the image
    always_comb begin
        v_al = (!i_pos.first_row && !i_pos.first_col)
             ? edb_pkg::sat_add(i_pixel_value, i_above_left, edb_pkg::WT_ABOVE_LEFT)
             : i_pixel_value;
        v_a  = !i_pos.first_row
             ? edb_pkg::sat_add(v_al, i_above, edb_pkg::WT_ABOVE)
             : v_al;
        v_ar = (!i_pos.first_row && !i_pos.last_col)
             ? edb_pkg::sat_add(v_a, i_above_right, edb_pkg::WT_ABOVE_RIGHT)
             : v_a;
        v_l  = !i_pos.first_col
             ? edb_pkg::sat_add(v_ar, i_left, edb_pkg::WT_LEFT)
             : v_ar;
    end

    assign o_is_white = (v_l > edb_pkg::THRESHOLD);
    assign o_err = o_is_white ? edb_pkg::t_err'({1'b0, v_l} - edb_pkg::WHITE_LEVEL)
                              : edb_pkg::t_err'({1'b0, v_l});

endmodule

`default_nettype wire

### rtl/edb_out_skid.sv
`default_nettype none

module edb_out_skid (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire edb_pkg::t_result i_in_word,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output edb_pkg::t_result      o_out_word,
    input  wire logic             i_out_stall
);

    logic             r_out_vld;
    logic             r_skid_vld;
    edb_pkg::t_result r_out;
    edb_pkg::t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_out_vld && i_out_stall) begin
            if (i_in_valid) begin
                r_skid_vld <= 1'b1;
            end
        end else begin
            r_out_vld  <= r_skid_vld || i_in_valid;
            r_skid_vld <= 1'b0;
        end
    end

    // Park the word in the skid slot while the output holds
    always_ff @(posedge i_clk) begin
        if (r_out_vld && i_out_stall) begin
            if (i_in_valid) begin
                r_skid <= i_in_word;
            end
        end else begin
            r_out <= r_skid_vld ? r_skid : i_in_word;
        end
    end

    assign o_in_stall  = r_skid_vld;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

### rtl/error_diffusion_binarizer.sv
// Error-diffusion binarizer: grey pixels in, one black/white pixel out each.
// Input channel: i_pix_valid / o_pix_stall carry i_pixel_value (8 bits) in
// raster order. A word is taken at a clock edge with valid high, stall low.
// Output channel: o_bin_valid / i_bin_stall carry o_is_white, o_row_end
// (last pixel of a row) and o_frame_end (last pixel of the frame).
// Configuration: APB-style port, image_width at byte 0, image_height at 4.
// Write only while the block is idle; pready is tied high.
// Each accepted result is registered in the output buffer. Throughput:
// one pixel per clock while the output is not stalled, set by the single
// compute stage feeding the output register; the line store reads the
// above-right error one pixel ahead through its registered read port.
// Stall: a two-entry output buffer (output register plus skid slot) keeps
// accepting while one result waits; o_pix_stall rises only when both hold.
// Reset (i_rst_n low, synchronous): counters and window error registers
// clear, size registers return to 512 x 512, both buffer entries empty.
// The line store is not cleared; the first row never reads it.
`default_nettype none

module error_diffusion_binarizer #(
    parameter int unsigned MAX_WIDTH = edb_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // pixel input
    input  wire logic                             i_pix_valid,
    output logic                                  o_pix_stall,
    input  wire logic [edb_pkg::PIX_W-1:0]        i_pixel_value,
    // binary output
    output logic                                  o_bin_valid,
    input  wire logic                             i_bin_stall,
    output logic                                  o_is_white,
    output logic                                  o_row_end,
    output logic                                  o_frame_end,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [edb_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [edb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [edb_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = ($clog2(MAX_WIDTH + 1) > edb_pkg::CFG_WIDTH_W)
                               ? $clog2(MAX_WIDTH + 1) : edb_pkg::CFG_WIDTH_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [edb_pkg::CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [edb_pkg::CFG_HEIGHT_W-1:0] r_cfg_height;
    logic                             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= edb_pkg::WIDTH_RESET;
            r_cfg_height <= edb_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                edb_pkg::REG_IDX_WIDTH: begin
                    r_cfg_width <= pwdata[edb_pkg::CFG_WIDTH_W-1:0];
                end
                edb_pkg::REG_IDX_HEIGHT: begin
                    r_cfg_height <= pwdata[edb_pkg::CFG_HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            edb_pkg::REG_IDX_WIDTH: begin
                prdata = edb_pkg::APB_DATA_W'(r_cfg_width);
            end
            edb_pkg::REG_IDX_HEIGHT: begin
                prdata = edb_pkg::APB_DATA_W'(r_cfg_height);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Effective frame size: zero counts as one, clamp to the maximum
    // ---------------------------------------------------------------
    logic [WW-1:0]                cfg_w_ext;
    logic [WW-1:0]                w_m1;
    logic [edb_pkg::ROW_W-1:0]    h_m1;

    always_comb begin
        cfg_w_ext = WW'(r_cfg_width);
        if (r_cfg_width == '0) begin
            w_m1 = '0;
        end else if (cfg_w_ext > WW'(MAX_WIDTH)) begin
            w_m1 = WW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = cfg_w_ext - WW'(1);
        end

        if (r_cfg_height == '0) begin
            h_m1 = '0;
        end else if (r_cfg_height > edb_pkg::CFG_HEIGHT_W'(edb_pkg::MAX_HEIGHT)) begin
            h_m1 = edb_pkg::ROW_W'(edb_pkg::MAX_HEIGHT - 1);
        end else begin
            h_m1 = edb_pkg::ROW_W'(r_cfg_height - edb_pkg::CFG_HEIGHT_W'(1));
        end
    end

    // ---------------------------------------------------------------
    // Position and neighbor error state
    // ---------------------------------------------------------------
    logic [CW-1:0]             r_col;
    logic [edb_pkg::ROW_W-1:0] r_row;
    edb_pkg::t_err             r_above;
    edb_pkg::t_err             r_above_left;
    edb_pkg::t_err             r_left;
    edb_pkg::t_err             r_col0_err;   // this row's column-0 error

    logic [CW-1:0]             n_col;
    logic [edb_pkg::ROW_W-1:0] n_row;
    edb_pkg::t_err             n_above;
    edb_pkg::t_err             n_above_left;
    edb_pkg::t_err             n_left;

    logic                      accept;
    logic                      last_col;
    logic                      last_row;
    edb_pkg::t_pos             pos;
    edb_pkg::t_err             above_right;
    edb_pkg::t_err             pix_err;
    logic                      pix_white;
    edb_pkg::t_result          result;
    logic [CW-1:0]             rd_addr;

    assign accept   = i_pix_valid && !o_pix_stall;
    assign last_col = (WW'(r_col) >= w_m1);
    assign last_row = (r_row >= h_m1);

    assign pos.first_row = (r_row == '0);
    assign pos.first_col = (r_col == '0);
    assign pos.last_col  = last_col;

    edb_diffuse u_diffuse (
        .i_pixel_value (i_pixel_value),
        .i_above_left  (r_above_left),
        .i_above       (r_above),
        .i_above_right (above_right),
        .i_left        (r_left),
        .i_pos         (pos),
        .o_is_white    (pix_white),
        .o_err         (pix_err)
    );

    // Advance the raster position and shift the error window. At a row end
    // the next above error is column 0 of the row just done, which is this
    // very pixel when the row is one pixel wide.
    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_above      = r_above;
        n_above_left = r_above_left;
        n_left       = r_left;
        if (accept) begin
            if (last_col) begin
                n_col        = '0;
                n_row        = last_row ? '0 : r_row + edb_pkg::ROW_W'(1);
                n_above      = pos.first_col ? pix_err : r_col0_err;
                n_above_left = '0;
                n_left       = '0;
            end else begin
                n_col        = r_col + CW'(1);
                n_above      = above_right;
                n_above_left = r_above;
                n_left       = pix_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_above      <= '0;
            r_above_left <= '0;
            r_left       <= '0;
        end else begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_above      <= n_above;
            r_above_left <= n_above_left;
            r_left       <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && pos.first_col) begin
            r_col0_err <= pix_err;
        end
    end

    // ---------------------------------------------------------------
    // Line store: write this pixel's error, prefetch the above-right
    // error for the next position
    // ---------------------------------------------------------------
    assign rd_addr = n_col + CW'(1);

    edb_line_mem #(
        .AW (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_col),
        .i_wr_data (pix_err),
        .i_rd_addr (rd_addr),
        .o_rd_data (above_right)
    );

    // ---------------------------------------------------------------
    // Result buffer
    // ---------------------------------------------------------------
    edb_pkg::t_result out_word;

    assign result.is_white  = pix_white;
    assign result.row_end   = last_col;
    assign result.frame_end = last_col && last_row;

    edb_out_skid u_out_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (accept),
        .i_in_word   (result),
        .o_in_stall  (o_pix_stall),
        .o_out_valid (o_bin_valid),
        .o_out_word  (out_word),
        .i_out_stall (i_bin_stall)
    );

    assign o_is_white  = out_word.is_white;
    assign o_row_end   = out_word.row_end;
    assign o_frame_end = out_word.frame_end;

`ifndef SYNTHESIS
    // A pixel that closes a row restarts the column count
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last_col) |=> (r_col == '0))
        else $error("column count did not wrap at row end");

    // The last pixel of a frame restarts both counts
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last_col && last_row) |=> (r_row == '0 && r_col == '0))
        else $error("frame did not restart after its last pixel");

    // Input is only held off when a result is waiting at the output
    a_stall_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix_stall |-> o_bin_valid)
        else $error("input stalled with empty output");

    // A frame end word is always also a row end word
    a_frame_end_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bin_valid && o_frame_end) |-> o_row_end)
        else $error("frame end without row end");
`endif

endmodule

`default_nettype wire

### bench/edb_dither_checker.sv
`default_nettype none

module edb_dither_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_pix_valid,
    input  wire logic                             i_pix_stall,
    input  wire logic [edb_pkg::PIX_W-1:0]        i_pixel_value,
    input  wire logic                             i_bin_valid,
    input  wire logic                             i_bin_stall,
    input  wire logic                             i_is_white,
    input  wire logic                             i_row_end,
    input  wire logic                             i_frame_end,
    input  wire logic                             i_psel,
    input  wire logic                             i_penable,
    input  wire logic                             i_pwrite,
    input  wire logic                             i_pready,
    input  wire logic [edb_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  wire logic [edb_pkg::APB_DATA_W-1:0]   i_pwdata,
    input  wire logic [edb_pkg::APB_DATA_W-1:0]   i_prdata,
    output int                                    o_pending,
    output int                                    o_fail_count
);

    localparam int unsigned LINE_DEPTH = edb_pkg::MAX_WIDTH_DEF;

    logic [edb_pkg::CFG_WIDTH_W-1:0]  cfg_width;
    logic [edb_pkg::CFG_HEIGHT_W-1:0] cfg_height;
    int                               err_line [LINE_DEPTH];
    int                               err_up_left;
    int                               err_up;
    int                               err_left;
    int unsigned                      cur_col;
    int unsigned                      cur_row;
    edb_pkg::t_result                 dither_due_q [$];
    int                               pending_n = 0;
    int                               fail_n = 0;

    assign o_pending    = pending_n;
    assign o_fail_count = fail_n;

    // pix + share, share truncated toward zero, clamp to 0..255
    function automatic int add_share(input int pix, input int err, input int weight);
        int s;
        s = pix + (err * weight) / 16;
        if (s > int'(edb_pkg::PIX_MAX)) return int'(edb_pkg::PIX_MAX);
        if (s < 0) return 0;
        return s;
    endfunction

    // Advance the dither state by one pixel and return the binary word it gives.
    function automatic edb_pkg::t_result dither_pixel(input logic [edb_pkg::PIX_W-1:0] pix);
        int unsigned      w;
        int unsigned      h;
        int unsigned      x;
        int               v;
        int               err;
        int               up_right;
        logic             last_col;
        logic             last_row;
        edb_pkg::t_result r;
        w = cfg_width;
        h = cfg_height;
        if (w == 0) w = 1;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        if (h == 0) h = 1;
        if (h > edb_pkg::MAX_HEIGHT) h = edb_pkg::MAX_HEIGHT;
        x = cur_col;
        if (x >= LINE_DEPTH) x = LINE_DEPTH - 1;
        last_col = (x >= w - 1);
        last_row = (cur_row >= h - 1);

        err_up   = err_line[x];
        up_right = last_col ? 0 : err_line[x + 1];

        v = int'(pix);
        if (cur_row > 0) begin
            if (x > 0) v = add_share(v, err_up_left, edb_pkg::WT_ABOVE_LEFT);
            v = add_share(v, err_up, edb_pkg::WT_ABOVE);
            if (!last_col) v = add_share(v, up_right, edb_pkg::WT_ABOVE_RIGHT);
        end
        if (x > 0) v = add_share(v, err_left, edb_pkg::WT_LEFT);

        r.is_white = (v > int'(edb_pkg::THRESHOLD));
        err = r.is_white ? v - int'(edb_pkg::PIX_MAX) : v;

        err_line[x] = err;
        err_left    = err;
        err_up_left = err_up;
        if (last_col) begin
            cur_col     = 0;
            err_left    = 0;
            err_up_left = 0;
            cur_row     = last_row ? 0 : cur_row + 1;
        end else begin
            cur_col = x + 1;
        end
        r.row_end   = last_col;
        r.frame_end = last_col & last_row;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        edb_pkg::t_result               want;
        logic [edb_pkg::APB_DATA_W-1:0] reg_now;
        int                             bad;
        bad = 0;
        if (!i_rst_n) begin
            cfg_width   = edb_pkg::WIDTH_RESET;
            cfg_height  = edb_pkg::HEIGHT_RESET;
            foreach (err_line[i]) err_line[i] = 0;
            err_up_left = 0;
            err_up      = 0;
            err_left    = 0;
            cur_col     = 0;
            cur_row     = 0;
            dither_due_q.delete();
            pending_n <= 0;
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == edb_pkg::REG_IDX_HEIGHT) begin
                        cfg_height = i_pwdata[edb_pkg::CFG_HEIGHT_W-1:0];
                    end else begin
                        cfg_width = i_pwdata[edb_pkg::CFG_WIDTH_W-1:0];
                    end
                end else begin
                    reg_now = (i_paddr[2] == edb_pkg::REG_IDX_HEIGHT)
                            ? edb_pkg::APB_DATA_W'(cfg_height)
                            : edb_pkg::APB_DATA_W'(cfg_width);
                    if (i_prdata !== reg_now) begin
                        $error("prdata: expected %0d, got %0d", reg_now, i_prdata);
                        bad++;
                    end
                end
            end

            // retire the output word before queuing a new prediction
            if (i_bin_valid && !i_bin_stall) begin
                if (dither_due_q.size() == 0) begin
                    $error({"binary word with nothing expected: ",
                            "is_white %0b row_end %0b frame_end %0b"},
                           i_is_white, i_row_end, i_frame_end);
                    bad++;
                end else begin
                    want = dither_due_q.pop_front();
                    if (i_is_white !== want.is_white) begin
                        $error("is_white: expected %0d, got %0d", want.is_white, i_is_white);
                        bad++;
                    end
                    if (i_row_end !== want.row_end) begin
                        $error("row_end: expected %0d, got %0d", want.row_end, i_row_end);
                        bad++;
                    end
                    if (i_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0d, got %0d", want.frame_end, i_frame_end);
                        bad++;
                    end
                end
            end

            if (i_pix_valid && !i_pix_stall) begin
                dither_due_q.push_back(dither_pixel(i_pixel_value));
            end
            pending_n <= dither_due_q.size();
        end
        fail_n <= fail_n + bad;
    end

endmodule

`default_nettype wire

### bench/tb_error_diffusion_binarizer.sv
`default_nettype none

module tb_error_diffusion_binarizer;

    // Run limits: the slowest legal run stays far below the cycle limit.
    localparam int CYCLE_LIMIT         = 1_000_000;
    localparam int SETTLE_CYCLES       = 10;
    localparam int WORDS_PER_PHASE     = 140;

    // Clock, reset and every block input start at a known value.
    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_pix_valid   = 1'b0;
    logic [edb_pkg::PIX_W-1:0]      i_pixel_value = '0;
    logic                           i_bin_stall   = 1'b0;
    logic                           psel          = 1'b0;
    logic                           penable       = 1'b0;
    logic                           pwrite        = 1'b0;
    logic [edb_pkg::APB_ADDR_W-1:0] paddr         = '0;
    logic [edb_pkg::APB_DATA_W-1:0] pwdata        = '0;

    logic                           o_pix_stall;
    logic                           o_bin_valid;
    logic                           o_is_white;
    logic                           o_row_end;
    logic                           o_frame_end;
    logic [edb_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    int pending_words;
    int failures;

    // Idle rates in percent: how likely the sender is to idle before each word
    // (tried again after every idle), and how likely the receiver is to stall.
    int src_idle_pct  = 0;
    int bin_stall_pct = 0;
    int cycle_count   = 0;

    error_diffusion_binarizer u_dut (.*);

    edb_dither_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_valid   (i_pix_valid),
        .i_pix_stall   (o_pix_stall),
        .i_pixel_value (i_pixel_value),
        .i_bin_valid   (o_bin_valid),
        .i_bin_stall   (i_bin_stall),
        .i_is_white    (o_is_white),
        .i_row_end     (o_row_end),
        .i_frame_end   (o_frame_end),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .o_pending     (pending_words),
        .o_fail_count  (failures)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver side: stall at random, at the rate the current phase sets.
    always @(posedge i_clk) begin
        i_bin_stall <= ($urandom_range(99) < bin_stall_pct);
    end

    // Watchdog: give up when the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** error_diffusion_binarizer: FAILED **");
            $finish;
        end
    end

    // Offer one grey word, after random idle cycles, and hold it until taken.
    task automatic send_pixel(input logic [edb_pkg::PIX_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            i_pix_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_pix_valid   <= 1'b1;
        i_pixel_value <= value;
        do @(posedge i_clk); while (o_pix_stall);
    endtask

    // Drop valid and wait until every predicted binary word has come out.
    task automatic drain_pixels();
        i_pix_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the word at the
    // access edge. End with the bus idle so back-to-back calls never collide.
    task automatic cfg_write(input logic idx, input logic [edb_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Read back a register; the checker compares prdata at the access edge.
    task automatic cfg_read(input logic idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Grey levels with extra weight on the saturation and threshold corners.
    function automatic logic [edb_pkg::PIX_W-1:0] grey_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return edb_pkg::PIX_MAX;
            2:       return edb_pkg::THRESHOLD + edb_pkg::PIX_W'($urandom_range(1));
            default: return edb_pkg::PIX_W'($urandom_range(255));
        endcase
    endfunction

    // Whole frames of random size and content. Sizes change only between
    // frames, so row 0 of each frame writes every line entry before row 1
    // reads it. Junk in the unused upper register bits must be ignored.
    task automatic run_random_frames(input int target);
        int sent;
        int w;
        int h;
        int npix;
        int pick;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(99);
            if (pick < 5)       w = 0;
            else if (pick < 80) w = $urandom_range(12, 1);
            else                w = $urandom_range(80, 13);
            h = ($urandom_range(99) < 8) ? 0 : $urandom_range(6, 1);

            drain_pixels();
            cfg_write(edb_pkg::REG_IDX_WIDTH,
                      ($urandom & ~32'h7FF) | edb_pkg::APB_DATA_W'(w));
            cfg_write(edb_pkg::REG_IDX_HEIGHT,
                      ($urandom & ~32'h1FFF) | edb_pkg::APB_DATA_W'(h));
            if ($urandom_range(3) == 0) begin
                cfg_read(edb_pkg::REG_IDX_WIDTH);
                cfg_read(edb_pkg::REG_IDX_HEIGHT);
            end

            npix = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
            repeat (npix) begin
                send_pixel(grey_sample());
                sent++;
                // now and then hold off until the output side has caught up
                if ($urandom_range(99) < 2) drain_pixels();
            end
        end
    endtask

    initial begin : stimulus
        // 4x3 frame: threshold neighbors in row 0 push full-size errors down,
        // rows 1 and 2 then saturate high and low.
        logic [edb_pkg::PIX_W-1:0] frame4x3 [12];
        logic [edb_pkg::PIX_W-1:0] head6 [6];

        frame4x3 = '{8'd128, 8'd129, 8'd128, 8'd129,
                     8'd255, 8'd0,   8'd255, 8'd0,
                     8'd0,   8'd255, 8'd1,   8'd254};
        head6    = '{8'd10, 8'd200, 8'd128, 8'd129, 8'd60, 8'd190};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of both size registers
        cfg_read(edb_pkg::REG_IDX_WIDTH);
        cfg_read(edb_pkg::REG_IDX_HEIGHT);

        // width of zero acts as a one-pixel column: only the above share applies
        cfg_write(edb_pkg::REG_IDX_WIDTH, 32'd0);
        cfg_write(edb_pkg::REG_IDX_HEIGHT, 32'd3);
        cfg_read(edb_pkg::REG_IDX_WIDTH);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd128);
        drain_pixels();

        // small frame: first row, first and last column edges, saturation
        cfg_write(edb_pkg::REG_IDX_WIDTH, 32'd4);
        cfg_write(edb_pkg::REG_IDX_HEIGHT, 32'd3);
        foreach (frame4x3[i]) send_pixel(frame4x3[i]);
        drain_pixels();

        // size change mid-frame: stop at row 1 column 2, narrow the row so
        // the next word closes it, then cut the height so row 2 ends the frame
        cfg_write(edb_pkg::REG_IDX_HEIGHT, 32'd4);
        foreach (head6[i]) send_pixel(head6[i]);
        drain_pixels();
        cfg_write(edb_pkg::REG_IDX_WIDTH, 32'd2);
        send_pixel(8'd128);
        send_pixel(8'd250);
        drain_pixels();
        cfg_write(edb_pkg::REG_IDX_HEIGHT, 32'd2);
        send_pixel(8'd3);
        drain_pixels();

        // oversize registers: width past the line store and height past 4096
        // both clamp, so a long run stays inside one row or one frame; a
        // narrowed size then closes the row or the frame early
        src_idle_pct   = 20;
        bin_stall_pct <= 20;
        cfg_write(edb_pkg::REG_IDX_WIDTH, 32'd2047);
        cfg_write(edb_pkg::REG_IDX_HEIGHT, 32'd1);
        repeat (100) send_pixel(grey_sample());
        drain_pixels();
        cfg_write(edb_pkg::REG_IDX_WIDTH, 32'd1);
        send_pixel(grey_sample());
        drain_pixels();
        cfg_write(edb_pkg::REG_IDX_HEIGHT, 32'd8191);
        cfg_read(edb_pkg::REG_IDX_HEIGHT);
        repeat (60) send_pixel(grey_sample());
        drain_pixels();
        cfg_write(edb_pkg::REG_IDX_HEIGHT, 32'd1);
        send_pixel(grey_sample());

        // random frames under each idling mix
        src_idle_pct   = 0;
        bin_stall_pct <= 0;
        run_random_frames(WORDS_PER_PHASE);
        src_idle_pct   = 70;
        bin_stall_pct <= 0;
        run_random_frames(WORDS_PER_PHASE);
        src_idle_pct   = 0;
        bin_stall_pct <= 70;
        run_random_frames(WORDS_PER_PHASE);
        src_idle_pct   = 20;
        bin_stall_pct <= 20;
        run_random_frames(WORDS_PER_PHASE);

        // flush, then give a stray word time to show up
        drain_pixels();
        bin_stall_pct <= 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (failures == 0 && pending_words == 0) begin
            $display("** error_diffusion_binarizer: PASSED **");
        end else begin
            $display("** error_diffusion_binarizer: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
